/* hw/rtl/vrr_pkg.sv */
// Shared types, codes and helpers of the variable record ring log.
package vrr_pkg;

  localparam int unsigned BufferBytesDef = 240;
  localparam int unsigned HeaderBytes    = 12;
  localparam int unsigned MaxResults     = 64;
  localparam int unsigned WordsW         = 7;
  localparam int unsigned CountW         = 5;
  localparam int unsigned PadLenW        = 10;
  localparam int unsigned LenRdW         = 16;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_REJ  = 2'd1,
    ST_READ = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BEG_CHK,
    S_LEN0,
    S_LEN1,
    S_LEN2,
    S_BEG_WR,
    S_RD_SKIP,
    S_RD_B,
    S_RD_C,
    S_RD_OUT,
    S_RESP
  } state_e;

  // Padded record length: header plus payload rounded up to whole headers.
  // The division by twelve is a multiply by 683 / 2^13, exact for sizes up to 255.
  function automatic logic [PadLenW-1:0] pad_len(input logic [7:0] size);
    logic [8:0]  s11;
    logic [18:0] prod;
    logic [5:0]  q;
    s11  = {1'b0, size} + 9'd11;
    prod = 19'(s11) * 19'd683;
    q    = prod[18:13];
    return PadLenW'(q) * PadLenW'(HeaderBytes) + PadLenW'(HeaderBytes);
  endfunction

endpackage

/* hw/rtl/variable_record_ring_log_unit.sv */
// Top level of the variable record ring log: sequencer, state and result register.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-----------------------------------------------
//  input   | in_valid_i | in_stall_o  | req_type_i direction_i record_size_i
//          |            |             | data_byte_i last_seen_i
//  output  | out_valid_o| out_stall_i | status_o out_word_o word_valid_o last_word_o
//          |            |             | record_count_o sequence_res_o
//
// A begin evicts old records as needed and then writes its padded length; a read
// skips the records the reader already has and then gathers each result word;
// their pace is set by the single byte-wide store port and the one shared
// offset adder.
// Reset clears all control state; the store is not cleared and needs no sweep.
// Input is stalled whenever the sequencer is busy; a result waits in the output
// register and the sequencer stalls only when it must load another one.
module variable_record_ring_log_unit #(
  parameter int unsigned BufferBytes = vrr_pkg::BufferBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] direction_i,
  input  logic [7:0]  record_size_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] last_seen_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_word_o,
  output logic        word_valid_o,
  output logic        last_word_o,
  output logic [4:0]  record_count_o,
  output logic [31:0] sequence_res_o
);

  localparam int unsigned OffW = $clog2(BufferBytes);
  localparam int unsigned LenW = $clog2(BufferBytes + 1);
  localparam int unsigned CntW = $clog2(BufferBytes / vrr_pkg::HeaderBytes + 1);
  localparam int unsigned EW   = (LenW > vrr_pkg::PadLenW) ? LenW : vrr_pkg::PadLenW;
  localparam int unsigned WW   = vrr_pkg::WordsW;

  vrr_pkg::state_e state_q, state_d;

  logic [OffW-1:0]  oldest_q, oldest_d;
  logic [LenW-1:0]  used_q, used_d;
  logic [CntW-1:0]  held_q, held_d;
  logic [31:0]      tot_q, tot_d;
  logic [OffW-1:0]  wr_off_q, wr_off_d;
  logic [7:0]       pend_q, pend_d;
  logic [LenW-1:0]  plen_pend_q, plen_pend_d;
  logic [OffW-1:0]  a_q, a_d;
  logic [OffW-1:0]  pos_q, pos_d;
  logic [LenW-1:0]  i_q, i_d;
  logic [31:0]      dir_q, dir_d;
  logic [7:0]       size_q, size_d;
  logic [LenW-1:0]  plen_q, plen_d;
  logic [7:0]       lo_q, lo_d;
  logic [CntW-1:0]  skip_q, skip_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]  skipped_q, skipped_d;
  logic [WW-1:0]    words_q, words_d;
  logic [1:0]       bi_q, bi_d;
  logic [31:0]      word_q, word_d;
  logic             evict_q, evict_d;
  vrr_pkg::status_e resp_st_q, resp_st_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [31:0]      out_word_q, out_word_d;
  logic             word_valid_q, word_valid_d;
  logic             last_word_q, last_word_d;
  logic [4:0]       count_q, count_d;
  logic [31:0]      seq_q, seq_d;

  logic [OffW-1:0]  add_x, add_s;
  logic [LenW-1:0]  add_y;
  logic             ram_we;
  logic [OffW-1:0]  ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic             in_xfer, out_free;
  logic [vrr_pkg::PadLenW-1:0] plen_in;
  logic             size_bad;
  logic [31:0]      diff;
  logic             out_range;
  logic [vrr_pkg::LenRdW-1:0] len_raw;
  logic [LenW-1:0]  len_use;
  logic             need_evict;
  logic [LenW-1:0]  bytes_left;
  logic [LenW-1:0]  words_raw;
  logic [WW-1:0]    wcalc;
  logic [95:0]      hdr;
  logic [7:0]       wr_byte;
  vrr_pkg::req_e    req;

  vrr_wrap_add #(.BufferBytes(BufferBytes)) u_add (
    .x_i (add_x),
    .y_i (add_y),
    .s_o (add_s)
  );

  vrr_ram #(.Width(8), .Depth(BufferBytes)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != vrr_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign req        = vrr_pkg::req_e'(req_type_i);

  // Decode the request and the values the sequencer branches on
  always_comb begin
    plen_in    = vrr_pkg::pad_len(record_size_i);
    size_bad   = (record_size_i == 8'd0) || (EW'(plen_in) > EW'(BufferBytes));
    diff       = tot_q - last_seen_i;
    out_range  = (diff > 32'(held_q)) || (last_seen_i == 32'd0) || (tot_q == 32'd0) ||
                 (tot_q < last_seen_i);
    len_raw    = {ram_rdata, lo_q};
    len_use    = ((len_raw == '0) || (len_raw > vrr_pkg::LenRdW'(used_q))) ?
                 used_q : len_raw[LenW-1:0];
    need_evict = ((LenW'(BufferBytes) - used_q) < plen_q) && (held_q != '0);
    bytes_left = used_q - skipped_q;
    words_raw  = bytes_left >> 2;
    wcalc      = (32'(words_raw) > 32'(vrr_pkg::MaxResults)) ?
                 WW'(vrr_pkg::MaxResults) : WW'(words_raw);
    hdr        = {32'(plen_q), 24'd0, size_q, dir_q};
    wr_byte    = (i_q < LenW'(vrr_pkg::HeaderBytes)) ? hdr[{i_q[3:0], 3'b000} +: 8] : 8'd0;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vrr_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (req)
            vrr_pkg::REQ_BEGIN: state_d = size_bad ? vrr_pkg::S_RESP : vrr_pkg::S_BEG_CHK;
            vrr_pkg::REQ_DATA:  state_d = vrr_pkg::S_RESP;
            vrr_pkg::REQ_READ:  state_d = vrr_pkg::S_RD_SKIP;
            default:            state_d = vrr_pkg::S_IDLE;
          endcase
        end
      end
      vrr_pkg::S_BEG_CHK: state_d = need_evict ? vrr_pkg::S_LEN0 : vrr_pkg::S_BEG_WR;
      vrr_pkg::S_LEN0:    state_d = vrr_pkg::S_LEN1;
      vrr_pkg::S_LEN1:    state_d = vrr_pkg::S_LEN2;
      vrr_pkg::S_LEN2:    state_d = evict_q ? vrr_pkg::S_BEG_CHK : vrr_pkg::S_RD_SKIP;
      vrr_pkg::S_BEG_WR: begin
        if (i_q == plen_q - LenW'(1)) begin
          state_d = vrr_pkg::S_RESP;
        end
      end
      vrr_pkg::S_RD_SKIP: begin
        if (skip_q != '0) begin
          state_d = vrr_pkg::S_LEN0;
        end else begin
          state_d = (wcalc == '0) ? vrr_pkg::S_RESP : vrr_pkg::S_RD_B;
        end
      end
      vrr_pkg::S_RD_B: state_d = vrr_pkg::S_RD_C;
      vrr_pkg::S_RD_C: state_d = (bi_q == 2'd3) ? vrr_pkg::S_RD_OUT : vrr_pkg::S_RD_B;
      vrr_pkg::S_RD_OUT: begin
        if (out_free) begin
          state_d = (words_q == WW'(1)) ? vrr_pkg::S_IDLE : vrr_pkg::S_RD_B;
        end
      end
      vrr_pkg::S_RESP: begin
        if (out_free) begin
          state_d = vrr_pkg::S_IDLE;
        end
      end
      default: state_d = vrr_pkg::S_IDLE;
    endcase
  end

  // Datapath, store port, shared adder and result register per state
  always_comb begin
    oldest_d     = oldest_q;
    used_d       = used_q;
    held_d       = held_q;
    tot_d        = tot_q;
    wr_off_d     = wr_off_q;
    pend_d       = pend_q;
    plen_pend_d  = plen_pend_q;
    a_d          = a_q;
    pos_d        = pos_q;
    i_d          = i_q;
    dir_d        = dir_q;
    size_d       = size_q;
    plen_d       = plen_q;
    lo_d         = lo_q;
    skip_d       = skip_q;
    cnt_d        = cnt_q;
    skipped_d    = skipped_q;
    words_d      = words_q;
    bi_d         = bi_q;
    word_d       = word_q;
    evict_d      = evict_q;
    resp_st_d    = resp_st_q;
    add_x        = a_q;
    add_y        = LenW'(1);
    ram_we       = 1'b0;
    ram_addr     = a_q;
    ram_wdata    = wr_byte;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    out_word_d   = out_word_q;
    word_valid_d = word_valid_q;
    last_word_d  = last_word_q;
    count_d      = count_q;
    seq_d        = seq_q;

    unique case (state_q)
      vrr_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (req)
            vrr_pkg::REQ_BEGIN: begin
              resp_st_d = vrr_pkg::ST_REJ;
              dir_d     = direction_i;
              size_d    = record_size_i;
              plen_d    = LenW'(plen_in);
            end
            vrr_pkg::REQ_DATA: begin
              if (pend_q == 8'd0) begin
                resp_st_d = vrr_pkg::ST_REJ;
              end else begin
                resp_st_d = vrr_pkg::ST_OK;
                ram_we    = 1'b1;
                ram_addr  = wr_off_q;
                ram_wdata = data_byte_i;
                add_x     = wr_off_q;
                wr_off_d  = add_s;
                pend_d    = pend_q - 8'd1;
                // Commit on the last payload byte
                if (pend_q == 8'd1) begin
                  used_d = used_q + plen_pend_q;
                  held_d = held_q + CntW'(1);
                  tot_d  = tot_q + 32'd1;
                end
              end
            end
            vrr_pkg::REQ_READ: begin
              resp_st_d = vrr_pkg::ST_READ;
              pos_d     = oldest_q;
              skipped_d = '0;
              if (out_range) begin
                skip_d = '0;
                cnt_d  = held_q;
              end else begin
                cnt_d  = diff[CntW-1:0];
                skip_d = held_q - diff[CntW-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      vrr_pkg::S_BEG_CHK: begin
        add_x = oldest_q;
        if (need_evict) begin
          add_y   = LenW'(8);
          a_d     = add_s;
          evict_d = 1'b1;
        end else begin
          add_y = (held_q == '0) ? '0 : used_q;
          a_d   = add_s;
          i_d   = '0;
          if (held_q == '0) begin
            used_d = '0;
          end
        end
      end
      vrr_pkg::S_LEN0: begin
        a_d = add_s;
      end
      vrr_pkg::S_LEN1: begin
        lo_d = ram_rdata;
      end
      vrr_pkg::S_LEN2: begin
        if (evict_q) begin
          // Drop the oldest record
          add_x    = oldest_q;
          add_y    = len_use;
          oldest_d = add_s;
          used_d   = used_q - len_use;
          held_d   = held_q - CntW'(1);
        end else begin
          // Step over a record the reader already has
          add_x     = pos_q;
          add_y     = len_use;
          pos_d     = add_s;
          skipped_d = skipped_q + len_use;
          skip_d    = skip_q - CntW'(1);
        end
      end
      vrr_pkg::S_BEG_WR: begin
        ram_we = 1'b1;
        a_d    = add_s;
        i_d    = i_q + LenW'(1);
        if (i_q == LenW'(vrr_pkg::HeaderBytes - 1)) begin
          wr_off_d = add_s;
        end
        if (i_q == plen_q - LenW'(1)) begin
          pend_d      = size_q;
          plen_pend_d = plen_q;
          resp_st_d   = vrr_pkg::ST_OK;
        end
      end
      vrr_pkg::S_RD_SKIP: begin
        if (skip_q != '0) begin
          add_x   = pos_q;
          add_y   = LenW'(8);
          a_d     = add_s;
          evict_d = 1'b0;
        end else begin
          a_d     = pos_q;
          bi_d    = 2'd0;
          words_d = wcalc;
        end
      end
      vrr_pkg::S_RD_B: begin
        a_d = add_s;
      end
      vrr_pkg::S_RD_C: begin
        word_d[{bi_q, 3'b000} +: 8] = ram_rdata;
        bi_d = bi_q + 2'd1;
      end
      vrr_pkg::S_RD_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          status_d     = vrr_pkg::ST_READ;
          out_word_d   = word_q;
          word_valid_d = 1'b1;
          words_d      = words_q - WW'(1);
          if (words_q == WW'(1)) begin
            last_word_d = 1'b1;
            count_d     = vrr_pkg::CountW'(cnt_q);
            seq_d       = tot_q;
          end else begin
            last_word_d = 1'b0;
            count_d     = '0;
            seq_d       = '0;
          end
        end
      end
      vrr_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          status_d     = resp_st_q;
          out_word_d   = '0;
          word_valid_d = 1'b0;
          last_word_d  = 1'b1;
          count_d      = '0;
          seq_d        = tot_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrr_pkg::S_IDLE;
      oldest_q    <= '0;
      used_q      <= '0;
      held_q      <= '0;
      tot_q       <= '0;
      wr_off_q    <= '0;
      pend_q      <= '0;
      plen_pend_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      used_q      <= used_d;
      held_q      <= held_d;
      tot_q       <= tot_d;
      wr_off_q    <= wr_off_d;
      pend_q      <= pend_d;
      plen_pend_q <= plen_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    pos_q        <= pos_d;
    i_q          <= i_d;
    dir_q        <= dir_d;
    size_q       <= size_d;
    plen_q       <= plen_d;
    lo_q         <= lo_d;
    skip_q       <= skip_d;
    cnt_q        <= cnt_d;
    skipped_q    <= skipped_d;
    words_q      <= words_d;
    bi_q         <= bi_d;
    word_q       <= word_d;
    evict_q      <= evict_d;
    resp_st_q    <= resp_st_d;
    status_q     <= status_d;
    out_word_q   <= out_word_d;
    word_valid_q <= word_valid_d;
    last_word_q  <= last_word_d;
    count_q      <= count_d;
    seq_q        <= seq_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_word_o     = out_word_q;
  assign word_valid_o   = word_valid_q;
  assign last_word_o    = last_word_q;
  assign record_count_o = count_q;
  assign sequence_res_o = seq_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= LenW'(BufferBytes))
    else $error("ring occupancy exceeds buffer size");

  a_empty_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (used_q == '0))
    else $error("empty ring still claims bytes");

  a_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_word_o) |-> (word_valid_o && (status_o == vrr_pkg::ST_READ)))
    else $error("non-final result that is not read data");

  a_pend_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 8'd0) |-> (plen_pend_q != '0))
    else $error("pending record without length");

endmodule

/* hw/rtl/vrr_ram.sv */
// Generic single-port RAM with registered read data.
module vrr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 240
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* hw/rtl/vrr_wrap_add.sv */
// Shared ring offset adder: (x + y) modulo the buffer size.
module vrr_wrap_add #(
  parameter int unsigned BufferBytes = vrr_pkg::BufferBytesDef
) (
  input  logic [$clog2(BufferBytes)-1:0]   x_i,
  input  logic [$clog2(BufferBytes+1)-1:0] y_i,
  output logic [$clog2(BufferBytes)-1:0]   s_o
);

  localparam int unsigned OffW = $clog2(BufferBytes);
  localparam int unsigned LenW = $clog2(BufferBytes + 1);
  localparam int unsigned SumW = LenW + 1;

  logic [SumW-1:0] sum;
  logic [SumW-1:0] red;

  // Add, then fold back once; both operands stay within one buffer length
  always_comb begin
    sum = SumW'(x_i) + SumW'(y_i);
    red = (sum >= SumW'(BufferBytes)) ? sum - SumW'(BufferBytes) : sum;
    s_o = red[OffW-1:0];
  end

endmodule
